@@ hdl/htfd_pkg.sv @@
`default_nettype none

package htfd_pkg;

  // crc-8 over each measurement word
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // conversion constants, raw full scale is 2^16 - 1
  localparam int RAW_FULL    = 65535;
  localparam int TEMP_SPAN   = 17500;
  localparam int TEMP_OFFSET = 4500;
  localparam int HUMI_SPAN   = 100;

  // position of the next byte in the six-byte frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // one byte through the crc, msb first
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(17500 * raw / 65535) - 4500, as 15-bit two's complement
  // division by 2^16 - 1: high half plus a single correction step
  function automatic logic [14:0] temp_from_raw(logic [15:0] raw);
    logic [30:0] prod;
    logic [14:0] q0;
    logic [16:0] rem;
    logic [14:0] q;
    logic [15:0] t;
    prod = 31'(raw) * 31'(TEMP_SPAN);
    q0   = prod[30:16];
    rem  = {1'b0, prod[15:0]} + 17'(q0);
    q    = q0 + 15'(rem >= 17'(RAW_FULL));
    t    = {1'b0, q} - 16'(TEMP_OFFSET);
    return t[14:0];
  endfunction

  // floor(100 * raw / 65535)
  function automatic logic [6:0] humi_from_raw(logic [15:0] raw);
    logic [22:0] prod;
    logic [6:0]  q0;
    logic [16:0] rem;
    prod = 23'(raw) * 23'(HUMI_SPAN);
    q0   = prod[22:16];
    rem  = {1'b0, prod[15:0]} + 17'(q0);
    return q0 + 7'(rem >= 17'(RAW_FULL));
  endfunction

endpackage

`default_nettype wire

@@ hdl/humidity_temp_frame_decoder.sv @@
// channel  | ports              | tdata (low bit up)                     | tuser
// ---------+--------------------+----------------------------------------+-------------------
// in       | in_t*  (slave)     | rx_byte[7:0]                           | frame_start
// out      | out_t* (master)    | temp_centi[14:0], humidity_pct[6:0], 0 | temp_ok, humi_ok
//
// one byte per cycle sustained: each byte is captured in an input register, then
// decoded (crc step, word assembly, conversion) in one pass into the frame state
// and, on the sixth byte, into the result register. rst_n is synchronous and
// restores the empty frame state. a full result register that is not taken holds
// the input register, and in_tready drops only then.
`default_nettype none

module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  wire logic        in_tuser,   // frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // temp_centi[14:0], humidity_pct[21:15], zero pad
  output logic [1:0]       out_tuser   // temp_ok, humi_ok
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // frame state
  pos_t        byte_pos_r, byte_pos_nxt;
  logic [7:0]  running_crc_r, running_crc_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [15:0] raw_word_r, raw_word_nxt;
  logic        temp_ok_seen_r, temp_ok_seen_nxt;
  logic [14:0] held_temp_r, held_temp_nxt;
  logic [6:0]  held_humidity_r, held_humidity_nxt;

  // result register
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [23:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  logic       s1_fire;
  logic       emit;
  logic       crc_ok;
  pos_t       pos_eff;
  logic [7:0] crc_in;
  logic [7:0] crc_step;

  // the decode pass runs when the result register is free or being drained
  assign s1_fire   = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // frame position and crc seed after a start flag or a stray code
  always_comb begin
    pos_eff = byte_pos_r;
    crc_in  = running_crc_r;
    if (s1_start_r) begin
      pos_eff = POS_T_HI;
      crc_in  = CRC_INIT;
    end else begin
      case (byte_pos_r)
        POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO, POS_H_CRC: begin
          pos_eff = byte_pos_r;
        end
        default: begin
          pos_eff = POS_T_HI;
          crc_in  = CRC_INIT;
        end
      endcase
    end
  end

  assign crc_step = crc8_byte(crc_in, s1_byte_r);
  assign crc_ok   = (crc_in == s1_byte_r);

  // next position
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    if (s1_fire) begin
      case (pos_eff)
        POS_T_HI:  byte_pos_nxt = POS_T_LO;
        POS_T_LO:  byte_pos_nxt = POS_T_CRC;
        POS_T_CRC: byte_pos_nxt = POS_H_HI;
        POS_H_HI:  byte_pos_nxt = POS_H_LO;
        POS_H_LO:  byte_pos_nxt = POS_H_CRC;
        default:   byte_pos_nxt = POS_T_HI;
      endcase
    end
  end

  // datapath updates per position
  always_comb begin
    running_crc_nxt   = running_crc_r;
    high_byte_nxt     = high_byte_r;
    raw_word_nxt      = raw_word_r;
    temp_ok_seen_nxt  = temp_ok_seen_r;
    held_temp_nxt     = held_temp_r;
    held_humidity_nxt = held_humidity_r;
    emit              = 1'b0;
    if (s1_fire) begin
      case (pos_eff)
        POS_T_HI, POS_H_HI: begin
          running_crc_nxt = crc_step;
          high_byte_nxt   = s1_byte_r;
        end
        POS_T_LO, POS_H_LO: begin
          running_crc_nxt = crc_step;
          raw_word_nxt    = {high_byte_r, s1_byte_r};
        end
        POS_T_CRC: begin
          running_crc_nxt  = CRC_INIT;
          temp_ok_seen_nxt = crc_ok;
          if (crc_ok) begin
            held_temp_nxt = temp_from_raw(raw_word_r);
          end
        end
        default: begin
          running_crc_nxt = CRC_INIT;
          emit            = 1'b1;
          if (crc_ok) begin
            held_humidity_nxt = humi_from_raw(raw_word_r);
          end
        end
      endcase
    end
  end

  // input register and result register loads
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {2'b00, held_humidity_nxt, held_temp_r};
      out_tuser_nxt  = {crc_ok, temp_ok_seen_r};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_tvalid_r    <= 1'b0;
      byte_pos_r      <= POS_T_HI;
      running_crc_r   <= CRC_INIT;
      high_byte_r     <= '0;
      raw_word_r      <= '0;
      temp_ok_seen_r  <= 1'b0;
      held_temp_r     <= '0;
      held_humidity_r <= '0;
    end else begin
      s1_valid_r      <= s1_valid_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
      byte_pos_r      <= byte_pos_nxt;
      running_crc_r   <= running_crc_nxt;
      high_byte_r     <= high_byte_nxt;
      raw_word_r      <= raw_word_nxt;
      temp_ok_seen_r  <= temp_ok_seen_nxt;
      held_temp_r     <= held_temp_nxt;
      held_humidity_r <= held_humidity_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

`ifndef SYNTHESIS
  // the sixth byte of a frame always lands in the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && pos_eff == POS_H_CRC) |=> out_tvalid_r)
    else $error("frame end without result");

  // crc is back at its seed whenever a word is about to begin
  assert property (@(posedge clk) disable iff (!rst_n)
    (byte_pos_r == POS_T_HI || byte_pos_r == POS_H_HI) |-> running_crc_r == CRC_INIT)
    else $error("crc not reseeded at word start");

  // a failed humidity check reports the previously held humidity
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && pos_eff == POS_H_CRC && !crc_ok)
      |=> out_tdata_r[21:15] == $past(held_humidity_r))
    else $error("failed humidity word changed held value");
`endif

endmodule

`default_nettype wire
